[design/isc_pkg.sv]
// shared types, sizes and codes for the grayscale image scaler
// no dependencies
package isc_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned FRAC_BITS  = 12;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned CFG_SIZE_W = 9;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned POS_W  = COORD_W + SCALE_W;
  localparam int unsigned INT_W  = POS_W - FRAC_BITS;
  localparam int unsigned WGT_W  = FRAC_BITS + 1;
  localparam int unsigned HB_W   = PIX_W + FRAC_BITS;
  localparam int unsigned VB_W   = PIX_W + 2 * FRAC_BITS;
  localparam int unsigned ROW_IW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned COL_IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned IDX_W  = (ROW_IW > COL_IW) ? ROW_IW : COL_IW;
  localparam int unsigned MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);

  localparam int unsigned ONE_FX  = 1 << FRAC_BITS;
  localparam int unsigned HALF_FX = 1 << (FRAC_BITS - 1);

  // input word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // interpolation modes
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP     = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [PIX_W-1:0]   pixel_in;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]     idx0;
    logic [IDX_W-1:0]     idx1;
    logic [IDX_W-1:0]     near;
    logic [FRAC_BITS-1:0] frac;
  } axis_t;

endpackage

[design/image_scaler_nearest_bilinear_top.sv]
// grayscale image scaler: frame memory, coordinate mapping and blend
// depends on isc_pkg and isc_axis
//
// Usage: in_word carries either a load (kind 0), which writes pixel_in to
// the frame memory at (row, col), or a request (kind 1), which returns one
// out_word holding the scaled pixel and the echoed output position.
// Loads outside the memory are dropped. Registers are written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no
// request is in flight, which the block itself does not enforce.
// Flow: in_stall stays low after a load. A request holds in_stall high
// from its acceptance until its result enters the output register, so
// the next word waits until that request is done. The time is set by the
// single-port frame memory (one read a cycle, four reads for bilinear)
// and the multiply stages of the position and blend.
// Reset clears control state and loads the register defaults; the frame
// memory is not cleared and must be loaded before it is read.
// A stalled result sits in the output register; loads are still taken
// meanwhile, and a finished request waits in ST_OUT until the word is taken.
module image_scaler_nearest_bilinear_top
  import isc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_IDX   = 4'd2;
  localparam logic [3:0] ST_READ  = 4'd3;
  localparam logic [3:0] ST_DRAIN = 4'd4;
  localparam logic [3:0] ST_BLH   = 4'd5;
  localparam logic [3:0] ST_BLV   = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam int unsigned PHB_W = PIX_W + WGT_W;
  localparam int unsigned PV_W  = HB_W + WGT_W;

  function automatic logic [IDX_W-1:0] last_index(input logic [CFG_SIZE_W-1:0] v,
                                                  input int unsigned maxv);
    logic [IDX_W-1:0] r;
    if (v == '0) r = '0;
    else if (32'(v) > maxv) r = IDX_W'(maxv - 1);
    else r = IDX_W'(32'(v) - 32'd1);
    return r;
  endfunction

  // configuration
  logic [CFG_SIZE_W-1:0] src_width_r;
  logic [CFG_SIZE_W-1:0] src_height_r;
  logic [SCALE_W-1:0]    inv_scale_r;
  logic                  interp_r;

  // control
  logic [3:0]           state_r, state_nxt;
  logic [1:0]           rd_cnt_r, rd_cnt_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [1:0]           rd_tag_r, rd_tag_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // datapath
  logic [COORD_W-1:0]   req_row_r, req_col_r;
  logic [POS_W-1:0]     pos_y_r, pos_x_r;
  axis_t                ay_r, ax_r, ay, ax;
  logic [PIX_W-1:0]     pix_r [4];
  logic [HB_W-1:0]      hb_top_r, hb_bot_r;
  logic [VB_W-1:0]      vb_a_r, vb_b_r;
  logic [PIX_W-1:0]     res_r;
  out_word_t            out_word_r;

  // frame memory
  logic [PIX_W-1:0]     frame_mem [MEM_DEPTH];
  logic [PIX_W-1:0]     rd_data_r;
  logic                 mem_we, rd_en;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [IDX_W-1:0]     rd_row, rd_col;

  logic                 in_acc;
  logic [IDX_W-1:0]     last_row, last_col;
  logic [1:0]           rd_last;
  logic [WGT_W-1:0]     wx0, wy0, wx1, wy1;
  logic [PHB_W-1:0]     top_full, bot_full;
  logic [VB_W-1:0]      vb_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign last_row = last_index(src_height_r, MAX_HEIGHT);
  assign last_col = last_index(src_width_r, MAX_WIDTH);

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= CFG_SIZE_W'(256);
      src_height_r <= CFG_SIZE_W'(256);
      inv_scale_r  <= SCALE_W'(2048);
      interp_r     <= MODE_BILINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[CFG_SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[CFG_SIZE_W-1:0];
        CFG_INV_SCALE:  inv_scale_r  <= cfg_data[SCALE_W-1:0];
        CFG_INTERP:     interp_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // load path
  assign mem_we  = in_acc && (in_word.kind == KIND_LOAD) &&
                   (32'(in_word.row) < MAX_HEIGHT) && (32'(in_word.col) < MAX_WIDTH);
  assign wr_addr = ADDR_W'(in_word.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_word.col);

  // read path
  assign rd_en   = (state_r == ST_READ);
  assign rd_last = (interp_r == MODE_BILINEAR) ? 2'd3 : 2'd0;

  always_comb begin
    if (interp_r == MODE_NEAREST) begin
      rd_row = ay_r.near;
      rd_col = ax_r.near;
    end else begin
      rd_row = rd_cnt_r[1] ? ay_r.idx1 : ay_r.idx0;
      rd_col = rd_cnt_r[0] ? ax_r.idx1 : ax_r.idx0;
    end
  end

  assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= in_word.pixel_in;
    end else if (rd_en) begin
      rd_data_r <= frame_mem[rd_addr];
    end
  end

  isc_axis u_axis_y (.pos(pos_y_r), .last(last_row), .axis(ay));
  isc_axis u_axis_x (.pos(pos_x_r), .last(last_col), .axis(ax));

  // blend weights and sums
  assign wx1 = WGT_W'(ax_r.frac);
  assign wy1 = WGT_W'(ay_r.frac);
  assign wx0 = WGT_W'(ONE_FX) - wx1;
  assign wy0 = WGT_W'(ONE_FX) - wy1;

  assign top_full = PHB_W'(pix_r[0]) * PHB_W'(wx0) + PHB_W'(pix_r[1]) * PHB_W'(wx1);
  assign bot_full = PHB_W'(pix_r[2]) * PHB_W'(wx0) + PHB_W'(pix_r[3]) * PHB_W'(wx1);
  assign vb_sum   = vb_a_r + vb_b_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_tag_nxt    = rd_tag_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_word.kind == KIND_REQ) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_IDX;
      ST_IDX: begin
        rd_cnt_nxt = 2'd0;
        state_nxt  = ST_READ;
      end
      ST_READ: begin
        rd_pend_nxt = 1'b1;
        rd_tag_nxt  = rd_cnt_r;
        rd_cnt_nxt  = rd_cnt_r + 2'd1;
        if (rd_cnt_r == rd_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = (interp_r == MODE_BILINEAR) ? ST_BLH : ST_OUT;
      ST_BLH:   state_nxt = ST_BLV;
      ST_BLV:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= 2'd0;
      rd_pend_r   <= 1'b0;
      rd_tag_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_tag_r    <= rd_tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_word.kind == KIND_REQ) begin
      req_row_r <= in_word.row;
      req_col_r <= in_word.col;
    end
    if (state_r == ST_MUL) begin
      pos_y_r <= POS_W'(req_row_r) * POS_W'(inv_scale_r);
      pos_x_r <= POS_W'(req_col_r) * POS_W'(inv_scale_r);
    end
    if (state_r == ST_IDX) begin
      ay_r <= ay;
      ax_r <= ax;
    end
    if (rd_pend_r) begin
      pix_r[rd_tag_r] <= rd_data_r;
    end
    if (state_r == ST_BLH) begin
      hb_top_r <= HB_W'(top_full);
      hb_bot_r <= HB_W'(bot_full);
    end
    if (state_r == ST_BLV) begin
      vb_a_r <= VB_W'(PV_W'(hb_top_r) * PV_W'(wy0));
      vb_b_r <= VB_W'(PV_W'(hb_bot_r) * PV_W'(wy1));
    end
    if (state_r == ST_SUM) begin
      res_r <= vb_sum[VB_W-1 -: PIX_W];
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_word_r.pixel_out <= (interp_r == MODE_BILINEAR) ? res_r : pix_r[0];
      out_word_r.out_row   <= req_row_r;
      out_word_r.out_col   <= req_col_r;
    end
  end

endmodule

[design/isc_axis.sv]
// maps one fixed-point source position to nearest index, neighbour indexes and fraction
// depends on isc_pkg
module isc_axis
  import isc_pkg::*;
(
  input  logic [POS_W-1:0] pos,
  input  logic [IDX_W-1:0] last,
  output axis_t            axis
);

  localparam int unsigned NI_W = POS_W + 1 - FRAC_BITS;

  logic [POS_W:0]     rnd;
  logic [NI_W-1:0]    ni;
  logic [INT_W-1:0]   ip;

  assign rnd = {1'b0, pos} + (POS_W + 1)'(HALF_FX);
  assign ni  = rnd[POS_W:FRAC_BITS];
  assign ip  = pos[POS_W-1:FRAC_BITS];

  always_comb begin
    axis.frac = pos[FRAC_BITS-1:0];
    axis.near = (32'(ni) > 32'(last)) ? last : IDX_W'(ni);
    if (32'(ip) >= 32'(last)) begin
      axis.idx0 = last;
      axis.idx1 = last;
    end else begin
      axis.idx0 = IDX_W'(ip);
      axis.idx1 = IDX_W'(ip) + IDX_W'(1);
    end
  end

endmodule

[design/isc_checker.sv]
// port-level checks for the image scaler top level, bound to it below
// depends on isc_pkg and image_scaler_nearest_bilinear_top
module isc_checker
  import isc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // a request blocks the input while it is worked on
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.kind == KIND_REQ |=> in_stall)
    else $error("input not stalled after a request");

  // a load leaves the input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.kind == KIND_LOAD |=> !in_stall)
    else $error("input stalled after a load");

  // a new result only appears at the end of request work
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word with no request in flight");

endmodule

bind image_scaler_nearest_bilinear_top isc_checker u_isc_checker (.*);

[tb/image_scaler_nearest_bilinear_top_tb.sv]
// testbench for the grayscale image scaler: loads source pixels, requests
// scaled pixels and checks each result word against its own frame copy
// depends on isc_pkg and image_scaler_nearest_bilinear_top
module image_scaler_nearest_bilinear_top_tb;
  import isc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS  = 900;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow registers, frame copy and pending scaled pixels
  logic [CFG_SIZE_W-1:0] src_width  = 9'd256;
  logic [CFG_SIZE_W-1:0] src_height = 9'd256;
  logic [SCALE_W-1:0]    inv_scale  = 16'd2048;
  logic                  interp     = MODE_BILINEAR;
  logic [PIX_W-1:0]      frame_copy [MEM_DEPTH];
  bit                    pix_written [MEM_DEPTH];
  out_word_t             pixels_due [$];
  out_word_t             pixel_want;

  int unsigned errors, words_sent, results_seen, loads_taken, loads_dropped, settings_used;
  int unsigned hold_left, stall_left;
  bit          tx_idle_on, rx_idle_on;

  image_scaler_nearest_bilinear_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_size(input logic [CFG_SIZE_W-1:0] v,
                                           input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // source neighbours and fraction along one axis; nearest gives one index, no fraction
  function automatic void map_axis(input logic [COORD_W-1:0] coord, input int unsigned lim,
                                   output int unsigned i0, output int unsigned i1,
                                   output int unsigned frac);
    longint unsigned pos, idx;
    pos = coord;
    pos = pos * inv_scale;
    if (interp == MODE_NEAREST) begin
      idx = (pos + HALF_FX) >> FRAC_BITS;
      i0 = (idx >= lim) ? lim - 1 : int'(idx);
      i1 = i0;
      frac = 0;
    end else begin
      idx = pos >> FRAC_BITS;
      frac = int'(pos & (ONE_FX - 1));
      if (idx >= lim - 1) begin
        i0 = lim - 1;
        i1 = lim - 1;
      end else begin
        i0 = int'(idx);
        i1 = int'(idx) + 1;
      end
    end
  endfunction

  function automatic logic [PIX_W-1:0] scaled_pixel(input logic [COORD_W-1:0] r,
                                                    input logic [COORD_W-1:0] c);
    int unsigned r0, r1, c0, c1, fy, fx;
    longint unsigned wx0, wx1, wy0, wy1, acc;
    map_axis(r, eff_size(src_height, MAX_HEIGHT), r0, r1, fy);
    map_axis(c, eff_size(src_width, MAX_WIDTH), c0, c1, fx);
    wx1 = fx;
    wx0 = ONE_FX - fx;
    wy1 = fy;
    wy0 = ONE_FX - fy;
    acc = frame_copy[r0 * MAX_WIDTH + c0] * wx0 * wy0
        + frame_copy[r0 * MAX_WIDTH + c1] * wx1 * wy0
        + frame_copy[r1 * MAX_WIDTH + c0] * wx0 * wy1
        + frame_copy[r1 * MAX_WIDTH + c1] * wx1 * wy1;
    acc = acc >> (2 * FRAC_BITS);
    return (acc > 255) ? 8'hFF : acc[PIX_W-1:0];
  endfunction

  // largest output coordinate that still maps inside the image, plus a little
  function automatic int unsigned reach(input logic [CFG_SIZE_W-1:0] v, input int unsigned maxv);
    longint unsigned ext;
    if (inv_scale == 0) return 4095;
    ext = (longint'(eff_size(v, maxv)) << FRAC_BITS) / inv_scale + 1;
    return (ext > 4095) ? 4095 : int'(ext);
  endfunction

  task automatic note_error(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, what);
  endtask

  // entered and left just after a falling edge; valid stays high on return
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (w.kind == KIND_LOAD) begin
      if (w.row < MAX_HEIGHT && w.col < MAX_WIDTH) begin
        frame_copy[w.row * MAX_WIDTH + w.col] = w.pixel_in;
        pix_written[w.row * MAX_WIDTH + w.col] = 1'b1;
        loads_taken++;
        words_sent++;
      end else begin
        loads_dropped++;
      end
    end else begin
      pixels_due.push_back('{pixel_out: scaled_pixel(w.row, w.col),
                             out_row: w.row, out_col: w.col});
      words_sent++;
    end
    @(negedge clk);
  endtask

  task automatic load_pixel(input int unsigned r, input int unsigned c,
                            input logic [PIX_W-1:0] p);
    send_word('{kind: KIND_LOAD, pixel_in: p, row: COORD_W'(r), col: COORD_W'(c)});
  endtask

  // loads any neighbour not yet written, then sends the request
  task automatic request_pixel(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    int unsigned r0, r1, c0, c1, fy, fx, addr;
    map_axis(r, eff_size(src_height, MAX_HEIGHT), r0, r1, fy);
    map_axis(c, eff_size(src_width, MAX_WIDTH), c0, c1, fx);
    for (int k = 0; k < 4; k++) begin
      addr = (k[1] ? r1 : r0) * MAX_WIDTH + (k[0] ? c1 : c0);
      if (!pix_written[addr])
        load_pixel(addr / MAX_WIDTH, addr % MAX_WIDTH, PIX_W'($urandom));
    end
    send_word('{kind: KIND_REQ, pixel_in: PIX_W'($urandom), row: r, col: c});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_SRC_WIDTH:  src_width  = data[CFG_SIZE_W-1:0];
      CFG_SRC_HEIGHT: src_height = data[CFG_SIZE_W-1:0];
      CFG_INV_SCALE:  inv_scale  = data;
      CFG_INTERP:     interp     = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // spare upper bits of the data carry noise; the block keeps only the field
  task automatic apply_setting(input logic [CFG_SIZE_W-1:0] w, input logic [CFG_SIZE_W-1:0] h,
                               input logic [SCALE_W-1:0] s, input logic m);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_SRC_WIDTH, {junk[CFG_DATA_W-1:CFG_SIZE_W], w});
    write_reg(CFG_SRC_HEIGHT, {junk[CFG_DATA_W-1:CFG_SIZE_W], h});
    write_reg(CFG_INV_SCALE, s);
    write_reg(CFG_INTERP, {junk[CFG_DATA_W-1:1], m});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CFG_SIZE_W-1:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return CFG_SIZE_W'($urandom_range(1, 8));
    if (sel == 7) return '0;
    if (sel == 8) return CFG_SIZE_W'($urandom_range(200, 256));
    return CFG_SIZE_W'($urandom_range(257, 511));
  endfunction

  // small images are filled whole, then mostly in-range requests with some noise
  task automatic run_phase(input int unsigned n);
    int unsigned sel, wr, hr, w, h;
    w  = eff_size(src_width, MAX_WIDTH);
    h  = eff_size(src_height, MAX_HEIGHT);
    wr = reach(src_width, MAX_WIDTH);
    hr = reach(src_height, MAX_HEIGHT);
    if (w * h <= 64) begin
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          load_pixel(r, c, PIX_W'($urandom));
    end
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)
        request_pixel(COORD_W'($urandom_range(0, hr)), COORD_W'($urandom_range(0, wr)));
      else if (sel < 85)
        request_pixel(COORD_W'($urandom), COORD_W'($urandom));
      else if (sel < 95)
        load_pixel($urandom_range(0, MAX_HEIGHT - 1), $urandom_range(0, MAX_WIDTH - 1),
                   PIX_W'($urandom));
      else
        load_pixel($urandom_range(0, 4095), $urandom_range(MAX_WIDTH, 4095), PIX_W'($urandom));
    end
  endtask

  task automatic test_reset_defaults();
    load_pixel(0, 0, 8'h00);
    load_pixel(0, 1, 8'hFF);
    load_pixel(1, 0, 8'hFF);
    load_pixel(1, 1, 8'h00);
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd0, 12'd1);
    request_pixel(12'd1, 12'd1);
    request_pixel(12'd4095, 12'd4095);
  endtask

  task automatic test_load_bounds();
    wait_idle();
    apply_setting(9'd4, 9'd4, 16'd4096, MODE_NEAREST);
    load_pixel(MAX_HEIGHT, 0, 8'hA5);
    load_pixel(0, MAX_WIDTH, 8'h5A);
    load_pixel(4095, 4095, 8'hFF);
    load_pixel(200, 200, 8'hC3);
    request_pixel(12'd3, 12'd3);
    wait_idle();
    apply_setting(9'd256, 9'd256, 16'd4096, MODE_NEAREST);
    request_pixel(12'd200, 12'd200);
  endtask

  task automatic test_size_extremes();
    wait_idle();
    apply_setting(9'd0, 9'd511, 16'd4096, MODE_NEAREST);
    request_pixel(12'd5, 12'd7);
    request_pixel(12'd4095, 12'd4095);
    wait_idle();
    apply_setting(9'd511, 9'd0, 16'd3000, MODE_BILINEAR);
    request_pixel(12'd4095, 12'd4095);
    request_pixel(12'd3, 12'd9);
  endtask

  task automatic test_scale_extremes();
    wait_idle();
    apply_setting(9'd16, 9'd16, 16'd0, MODE_BILINEAR);
    request_pixel(12'd4095, 12'd17);
    wait_idle();
    apply_setting(9'd16, 9'd16, 16'hFFFF, MODE_NEAREST);
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd1, 12'd1);
    request_pixel(12'd4095, 12'd0);
    wait_idle();
    apply_setting(9'd16, 9'd16, 16'd1, MODE_BILINEAR);
    request_pixel(12'd4095, 12'd4095);
  endtask

  task automatic test_rounding_and_blend();
    wait_idle();
    apply_setting(9'd8, 9'd8, 16'd2048, MODE_NEAREST);
    request_pixel(12'd1, 12'd1);
    request_pixel(12'd3, 12'd5);
    wait_idle();
    apply_setting(9'd8, 9'd8, 16'd2047, MODE_NEAREST);
    request_pixel(12'd1, 12'd1);
    wait_idle();
    apply_setting(9'd8, 9'd8, 16'd1365, MODE_BILINEAR);
    request_pixel(12'd1, 12'd2);
    request_pixel(12'd7, 12'd4);
    request_pixel(12'd23, 12'd23);
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_backpressure();
    wait_idle();
    tx_idle_on = 1'b0;
    apply_setting(9'd4, 9'd4, 16'd1024, MODE_BILINEAR);
    hold_left = 300;
    run_phase(24);
    wait_idle();
  endtask

  task automatic test_random_settings();
    logic [SCALE_W-1:0] s;
    int unsigned sel;
    while (words_sent < RANDOM_WORDS) begin
      wait_idle();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 30) s = SCALE_W'($urandom_range(256, 16384));
      else if (sel < 45) s = SCALE_W'($urandom);
      else if (sel < 55) s = '0;
      else if (sel < 65) s = '1;
      else if (sel < 75) s = 16'd4096;
      else if (sel < 85) s = SCALE_W'($urandom_range(1, 255));
      else s = 16'd2048;
      apply_setting(pick_size(), pick_size(), s, logic'($urandom_range(0, 1)));
      run_phase($urandom_range(10, 40));
    end
  endtask

  task automatic test_tail_no_idle();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    apply_setting(9'd6, 9'd5, 16'd1500, MODE_BILINEAR);
    run_phase(60);
    wait_idle();
    apply_setting(9'd7, 9'd8, 16'd2900, MODE_NEAREST);
    run_phase(60);
  endtask

  // receiver stall: a long hold-off when one is set, else random bursts while rx idling is on
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        note_error($sformatf("result word with none pending: pixel %0d row %0d col %0d",
                             out_word.pixel_out, out_word.out_row, out_word.out_col));
      end else begin
        pixel_want = pixels_due.pop_front();
        results_seen++;
        if (out_word.pixel_out !== pixel_want.pixel_out ||
            out_word.out_row !== pixel_want.out_row ||
            out_word.out_col !== pixel_want.out_col)
          note_error($sformatf({"mismatch: expected pixel %0d row %0d col %0d, ",
                                "got pixel %0d row %0d col %0d"},
                               pixel_want.pixel_out, pixel_want.out_row, pixel_want.out_col,
                               out_word.pixel_out, out_word.out_row, out_word.out_col));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timed out with %0d result words outstanding", pixels_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_load_bounds();
    test_size_extremes();
    test_scale_extremes();
    test_rounding_and_blend();
    test_output_backpressure();
    test_random_settings();
    test_tail_no_idle();
    wait_idle();

    $display("checked %0d scaled pixels from %0d stored loads over %0d register settings",
             results_seen, loads_taken, settings_used);
    $display("%0d loads fell outside the frame store; %0d errors", loads_dropped, errors);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
